[rtl/icy_pkg.sv]
// shared types, codes and constants of the icy metadata stream demux
// no dependencies; used by the channel interfaces and the top level
package icy_pkg;

   // bytes in one bank of the title store
   localparam int TITLE_MAX         = 256;
   localparam int INTERVAL_W        = 24;
   localparam int META_W            = 12;
   localparam int COUNT_W           = 12;
   localparam int KEYPOS_W          = 4;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [KEYPOS_W-1:0] KEY_LEN    = 4'd11;
   localparam logic [KEYPOS_W-1:0] KEYPOS_TOP = 4'd15;
   localparam logic [COUNT_W-1:0]  COUNT_TOP  = 12'd4095;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SEMI   = 8'h3b;
   localparam logic [7:0] CHAR_EQUALS = 8'h3d;
   localparam logic [7:0] CHAR_QUOTE  = 8'h27;

   // register index: byte address / 4
   localparam logic [CSR_ADDR_W-3:0] REG_DATA_INTERVAL = '0;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_READ    = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CLS_AUDIO = 3'd0,
      CLS_LEN   = 3'd1,
      CLS_META  = 3'd2,
      CLS_PASS  = 3'd3,
      CLS_NONE  = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      PH_AUDIO = 2'd0,
      PH_LEN   = 2'd1,
      PH_META  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      TX_KEY   = 2'd0,
      TX_VALUE = 2'd1,
      TX_SKIP  = 2'd2,
      TX_END   = 2'd3
   } text_type;

   typedef struct packed {
      text_type             phase;
      logic [KEYPOS_W-1:0]  keypos;
      logic                 match;
      logic [COUNT_W-1:0]   count;
      logic [7:0]           first;
      logic [7:0]           last;
   } parse_type;

   localparam parse_type PARSE_RESET = '{
      phase:  TX_KEY,
      keypos: '0,
      match:  1'b1,
      count:  '0,
      first:  '0,
      last:   '0
   };

   // characters of the StreamTitle key
   function automatic logic [7:0] key_char(input logic [KEYPOS_W-1:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = "S";
         4'd1:    c = "t";
         4'd2:    c = "r";
         4'd3:    c = "e";
         4'd4:    c = "a";
         4'd5:    c = "m";
         4'd6:    c = "T";
         4'd7:    c = "i";
         4'd8:    c = "t";
         4'd9:    c = "l";
         4'd10:   c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/icy_req_if.sv]
// request channel: one stream byte, title read or restart per transaction
// depends on icy_pkg
interface icy_req_if import icy_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] stream_byte;
   logic [7:0] title_index;

   modport source (output valid, kind, stream_byte, title_index, input ready);
   modport sink   (input valid, kind, stream_byte, title_index, output ready);
endinterface

[rtl/icy_rsp_if.sv]
// response channel: byte class, byte copy and committed title view
// depends on icy_pkg; the title length width follows TITLE_MAX
interface icy_rsp_if import icy_pkg::*; ();
   localparam int LEN_W = $clog2(TITLE_MAX + 1);

   logic             valid;
   logic             ready;
   logic [2:0]       byte_class;
   logic [7:0]       byte_out;
   logic             block_done;
   logic [7:0]       title_char;
   logic [LEN_W-1:0] title_length;
   logic             title_truncated;

   modport source (output valid, byte_class, byte_out, block_done, title_char,
                   title_length, title_truncated, input ready);
   modport sink   (input valid, byte_class, byte_out, block_done, title_char,
                   title_length, title_truncated, output ready);
endinterface

[rtl/icy_metadata_stream_demux_top.sv]
// Stream demux for in-band icy metadata. Each request transaction carries a stream byte
// (classified as audio, length byte, metadata or pass-through), a title read, or a framing
// restart; each yields exactly one response transaction. The block takes one transaction
// per cycle unless rsp.ready stalls it: an input register, then one pass of framing/parse
// logic whose results and the registered title store read land in the output register.
// The title store is a 2*TITLE_MAX byte memory, one write and one read port, not cleared
// at reset. The user writes data_interval over the APB port at address 0 while idle; the
// block itself does not enforce this. Depends on icy_pkg, icy_req_if, icy_rsp_if
module icy_metadata_stream_demux_top import icy_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   icy_req_if.sink               req,
   icy_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int LEN_W  = $clog2(TITLE_MAX + 1);
   localparam int ADDR_W = $clog2(2 * TITLE_MAX);
   localparam int CMP_W  = COUNT_W + 2;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             off;
      logic             cut;
   } commit_type;

   // quote stripping and length cap of a finished value
   function automatic commit_type commit_fn(input logic [COUNT_W-1:0] cnt,
                                            input logic [7:0] first,
                                            input logic [7:0] last);
      commit_type       res;
      logic [CMP_W-1:0] len;
      logic [CMP_W-1:0] cap;
      res.off = (cnt >= COUNT_W'(2)) && (first == CHAR_QUOTE) && (last == CHAR_QUOTE);
      len = CMP_W'(cnt) - (res.off ? CMP_W'(2) : CMP_W'(0));
      cap = CMP_W'(TITLE_MAX) - CMP_W'(res.off);
      res.cut = (len > cap);
      res.len = res.cut ? LEN_W'(cap) : LEN_W'(len);
      return res;
   endfunction

   // configuration
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic                  csr_write;
   logic                  csr_hit;

   // input register
   logic       a_valid_ff, a_valid_in;
   logic [1:0] a_kind_ff;
   logic [7:0] a_byte_ff;
   logic [7:0] a_index_ff;
   logic       adv;

   // block state
   phase_type             phase_ff, phase_in;
   logic [INTERVAL_W-1:0] audio_ff, audio_in;
   logic [INTERVAL_W-1:0] audio_base;
   logic [META_W-1:0]     meta_ff, meta_in;
   parse_type             parse_ff, parse_in;
   logic                  active_ff, active_in;
   logic                  work;
   logic [LEN_W-1:0]      work_len_ff, work_len_in;
   logic                  work_off_ff, work_off_in;
   logic [LEN_W-1:0]      shown_len_ff, shown_len_in;
   logic                  shown_off_ff, shown_off_in;
   logic [1:0]            cut_ff, cut_in;
   commit_type            cm;

   // title store ports
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        store_mem [2*TITLE_MAX];
   logic [7:0]        rd_ff;

   // output register
   logic             b_valid_ff, b_valid_in;
   class_type        cls_in;
   logic             done_in;
   logic [2:0]       b_class_ff;
   logic [7:0]       b_byte_ff;
   logic             b_done_ff;
   logic [LEN_W-1:0] b_len_ff;
   logic             b_trunc_ff;
   logic             b_char_ok_ff;
   logic             b_hit_ff;
   logic [7:0]       b_wdata_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_DATA_INTERVAL);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? CSR_DATA_W'(interval_ff) : '0;

   always_comb begin
      interval_in = interval_ff;
      if (csr_write) begin
         interval_in = pwdata[INTERVAL_W-1:0];
      end
   end

   // ---------------- input register ----------------
   assign adv        = a_valid_ff && (!b_valid_ff || rsp.ready);
   assign req.ready  = !a_valid_ff || adv;
   assign a_valid_in = (req.valid && req.ready) || (a_valid_ff && !adv);
   assign b_valid_in = adv || (b_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         a_kind_ff  <= req.kind;
         a_byte_ff  <= req.stream_byte;
         a_index_ff <= req.title_index;
      end
   end

   // ---------------- framing and parse update ----------------
   assign work       = ~active_ff;
   assign audio_base = (audio_ff == '0) ? interval_ff : audio_ff;
   assign waddr      = ADDR_W'(parse_ff.count) + (work ? ADDR_W'(TITLE_MAX) : ADDR_W'(0));

   always_comb begin
      phase_in     = phase_ff;
      audio_in     = audio_ff;
      meta_in      = meta_ff;
      parse_in     = parse_ff;
      active_in    = active_ff;
      work_len_in  = work_len_ff;
      work_off_in  = work_off_ff;
      shown_len_in = shown_len_ff;
      shown_off_in = shown_off_ff;
      cut_in       = cut_ff;
      cls_in       = CLS_NONE;
      done_in      = 1'b0;
      we           = 1'b0;
      cm           = commit_fn(parse_ff.count, parse_ff.first, parse_ff.last);
      if (adv) begin
         case (a_kind_ff)
            KIND_BYTE: begin
               if (interval_ff == '0) begin
                  cls_in = CLS_PASS;
               end else begin
                  case (phase_ff)
                     PH_LEN: begin
                        cls_in  = CLS_LEN;
                        meta_in = {a_byte_ff, 4'b0000};
                        if (a_byte_ff == '0) begin
                           phase_in = PH_AUDIO;
                           audio_in = interval_ff;
                        end else begin
                           phase_in     = PH_META;
                           parse_in     = PARSE_RESET;
                           work_len_in  = '0;
                           work_off_in  = 1'b0;
                           cut_in[work] = 1'b0;
                        end
                     end
                     PH_META: begin
                        cls_in = CLS_META;
                        case (parse_ff.phase)
                           TX_KEY: begin
                              if (a_byte_ff == CHAR_NUL) begin
                                 parse_in.phase = TX_END;
                              end else if (a_byte_ff == CHAR_SEMI) begin
                                 parse_in = PARSE_RESET;
                              end else if (a_byte_ff == CHAR_EQUALS) begin
                                 if (parse_ff.match && parse_ff.keypos == KEY_LEN) begin
                                    parse_in.phase = TX_VALUE;
                                    parse_in.count = '0;
                                 end else begin
                                    parse_in.phase = TX_SKIP;
                                 end
                              end else begin
                                 if (parse_ff.keypos >= KEY_LEN ||
                                     key_char(parse_ff.keypos) != a_byte_ff) begin
                                    parse_in.match = 1'b0;
                                 end
                                 if (parse_ff.keypos != KEYPOS_TOP) begin
                                    parse_in.keypos = parse_ff.keypos + 1'b1;
                                 end
                              end
                           end
                           TX_VALUE: begin
                              if (a_byte_ff == CHAR_NUL || a_byte_ff == CHAR_SEMI ||
                                  a_byte_ff == CHAR_EQUALS) begin
                                 work_len_in  = cm.len;
                                 work_off_in  = cm.off;
                                 cut_in[work] = cm.cut;
                                 if (a_byte_ff == CHAR_NUL) begin
                                    parse_in.phase = TX_END;
                                 end else if (a_byte_ff == CHAR_SEMI) begin
                                    parse_in = PARSE_RESET;
                                 end else begin
                                    parse_in.phase = TX_SKIP;
                                 end
                              end else begin
                                 we = (CMP_W'(parse_ff.count) < CMP_W'(TITLE_MAX));
                                 if (parse_ff.count == '0) begin
                                    parse_in.first = a_byte_ff;
                                 end
                                 parse_in.last = a_byte_ff;
                                 if (parse_ff.count != COUNT_TOP) begin
                                    parse_in.count = parse_ff.count + 1'b1;
                                 end
                              end
                           end
                           TX_SKIP: begin
                              if (a_byte_ff == CHAR_NUL) begin
                                 parse_in.phase = TX_END;
                              end else if (a_byte_ff == CHAR_SEMI) begin
                                 parse_in = PARSE_RESET;
                              end
                           end
                           default: ;
                        endcase
                        meta_in = (meta_ff != '0) ? meta_ff - 1'b1 : '0;
                        if (meta_in == '0) begin
                           // end of block: close an open value, then swap banks
                           if (parse_in.phase == TX_VALUE) begin
                              cm           = commit_fn(parse_in.count, parse_in.first,
                                                       parse_in.last);
                              work_len_in  = cm.len;
                              work_off_in  = cm.off;
                              cut_in[work] = cm.cut;
                           end
                           active_in    = ~active_ff;
                           shown_len_in = work_len_in;
                           shown_off_in = work_off_in;
                           done_in      = 1'b1;
                           parse_in     = PARSE_RESET;
                           phase_in     = PH_AUDIO;
                           audio_in     = interval_ff;
                        end
                     end
                     default: begin
                        cls_in   = CLS_AUDIO;
                        audio_in = audio_base - 1'b1;
                        phase_in = (audio_in == '0) ? PH_LEN : PH_AUDIO;
                     end
                  endcase
               end
            end
            KIND_RESTART: begin
               phase_in     = PH_AUDIO;
               audio_in     = interval_ff;
               meta_in      = '0;
               parse_in     = PARSE_RESET;
               work_len_in  = '0;
               work_off_in  = 1'b0;
               shown_len_in = '0;
               shown_off_in = 1'b0;
               cut_in       = '0;
            end
            KIND_READ: cls_in = CLS_NONE;
            default: ;
         endcase
      end
   end

   // read address follows the state after this transaction
   assign raddr = (active_in ? ADDR_W'(TITLE_MAX) : ADDR_W'(0)) + ADDR_W'(shown_off_in)
                  + ADDR_W'(a_index_ff);

   // ---------------- title store ----------------
   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= a_byte_ff;
      end
      if (adv) begin
         rd_ff <= store_mem[raddr];
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         b_class_ff   <= cls_in;
         b_byte_ff    <= (a_kind_ff == KIND_BYTE) ? a_byte_ff : 8'h00;
         b_done_ff    <= done_in;
         b_len_ff     <= shown_len_in;
         b_trunc_ff   <= cut_in[active_in];
         b_char_ok_ff <= (CMP_W'(a_index_ff) < CMP_W'(shown_len_in));
         // same-cycle write to the read entry
         b_hit_ff     <= we && (waddr == raddr);
         b_wdata_ff   <= a_byte_ff;
      end
   end

   assign rsp.valid           = b_valid_ff;
   assign rsp.byte_class      = b_class_ff;
   assign rsp.byte_out        = b_byte_ff;
   assign rsp.block_done      = b_done_ff;
   assign rsp.title_length    = b_len_ff;
   assign rsp.title_truncated = b_trunc_ff;
   assign rsp.title_char      = !b_char_ok_ff ? 8'h00 : (b_hit_ff ? b_wdata_ff : rd_ff);

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         phase_ff     <= PH_AUDIO;
         audio_ff     <= '0;
         meta_ff      <= '0;
         parse_ff     <= PARSE_RESET;
         active_ff    <= 1'b0;
         work_len_ff  <= '0;
         work_off_ff  <= 1'b0;
         shown_len_ff <= '0;
         shown_off_ff <= 1'b0;
         cut_ff       <= '0;
      end else begin
         interval_ff  <= interval_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         phase_ff     <= phase_in;
         audio_ff     <= audio_in;
         meta_ff      <= meta_in;
         parse_ff     <= parse_in;
         active_ff    <= active_in;
         work_len_ff  <= work_len_in;
         work_off_ff  <= work_off_in;
         shown_len_ff <= shown_len_in;
         shown_off_ff <= shown_off_in;
         cut_ff       <= cut_in;
      end
   end

   // ---------------- assertions ----------------
   a_write_in_value: assert property (@(posedge clock) disable iff (reset)
      we |-> (phase_ff == PH_META) && (parse_ff.phase == TX_VALUE))
      else $error("title store written outside a value");

   a_done_swaps: assert property (@(posedge clock) disable iff (reset)
      adv && done_in |=> active_ff != $past(active_ff))
      else $error("block end without bank swap");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(active_ff) && $stable(phase_ff) && $stable(shown_len_ff))
      else $error("state changed without a transaction");

   a_pass_keeps_framing: assert property (@(posedge clock) disable iff (reset)
      adv && (a_kind_ff == KIND_BYTE) && (interval_ff == '0)
      |=> $stable(phase_ff) && $stable(audio_ff))
      else $error("pass-through byte changed framing");

   a_shown_fits: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(shown_len_ff) + CMP_W'(shown_off_ff) <= CMP_W'(TITLE_MAX))
      else $error("shown title exceeds its bank");

endmodule

[tb/tb_icy_metadata_stream_demux_top.sv]
// self-checking testbench for icy_metadata_stream_demux_top: framing, title parse and store
// depends on icy_pkg, icy_req_if, icy_rsp_if and the top level; predicts every transaction
`timescale 1ns / 1ps

module tb_icy_metadata_stream_demux_top;
   import icy_pkg::*;

   localparam int TITLE_CAP = TITLE_MAX;
   localparam int QUIET_LIMIT = 5000;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = {REG_DATA_INTERVAL, 2'b00};
   localparam logic [8*11-1:0] TITLE_KEY = "StreamTitle";

   typedef struct packed {
      class_type  cls;
      logic [7:0] data;
      logic       done;
      logic [7:0] ch;
      logic [8:0] len;
      logic       cut;
   } byte_report_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   icy_req_if req_if ();
   icy_rsp_if rsp_if ();

   icy_metadata_stream_demux_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predicted demux state
   logic [23:0] interval_reg;
   phase_type   frame_phase;
   logic [23:0] audio_left;
   logic [11:0] meta_left;
   text_type    text_phase;
   logic [3:0]  key_pos;
   logic        key_ok;
   logic [11:0] val_count;
   logic [7:0]  val_first;
   logic [7:0]  val_last;
   logic [7:0]  title_mem [0:2*TITLE_CAP-1];
   logic        bank;
   logic [8:0]  work_len;
   logic        work_off;
   logic [8:0]  shown_len;
   logic        shown_off;
   logic [1:0]  cut_bits;

   byte_report_type byte_reports[$];
   logic [7:0]      meta_text[$];

   int error_count;
   int responses_seen;
   int items_sent;
   int quiet_cycles;
   int send_idle_pct;
   int sink_stall_pct;
   int hold_left;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void restart_text();
      text_phase = TX_KEY;
      key_pos    = '0;
      key_ok     = 1'b1;
      val_count  = '0;
      val_first  = '0;
      val_last   = '0;
   endfunction

   function automatic void restart_audio();
      frame_phase = PH_AUDIO;
      audio_left  = interval_reg;
      meta_left   = '0;
   endfunction

   // close the value into the work bank, dropping one pair of enclosing quotes
   function automatic void commit_title();
      logic wb;
      logic off;
      int   len;
      int   cap;
      wb  = ~bank;
      off = 1'b0;
      len = int'(val_count);
      if (val_count >= 2 && val_first == CHAR_QUOTE && val_last == CHAR_QUOTE) begin
         off = 1'b1;
         len = int'(val_count) - 2;
      end
      cap = TITLE_CAP - int'(off);
      cut_bits[wb] = 1'b0;
      if (len > cap) begin
         len = cap;
         cut_bits[wb] = 1'b1;
      end
      work_len = 9'(len);
      work_off = off;
   endfunction

   function automatic byte_report_type classify_and_parse(input logic [1:0] kind,
                                                          input logic [7:0] b,
                                                          input logic [7:0] idx);
      byte_report_type r;
      logic            wb;
      r = '0;
      r.cls = CLS_NONE;
      wb = ~bank;
      if (kind == KIND_BYTE) begin
         r.data = b;
         if (interval_reg == '0) begin
            r.cls = CLS_PASS;
         end else if (frame_phase == PH_LEN) begin
            r.cls = CLS_LEN;
            meta_left = {b, 4'b0000};
            if (meta_left == '0) begin
               restart_audio();
            end else begin
               frame_phase = PH_META;
               restart_text();
               work_len = '0;
               work_off = 1'b0;
               cut_bits[wb] = 1'b0;
            end
         end else if (frame_phase == PH_META) begin
            r.cls = CLS_META;
            case (text_phase)
               TX_KEY: begin
                  if (b == CHAR_NUL) begin
                     text_phase = TX_END;
                  end else if (b == CHAR_SEMI) begin
                     restart_text();
                  end else if (b == CHAR_EQUALS) begin
                     if (key_ok && key_pos == KEY_LEN) begin
                        text_phase = TX_VALUE;
                        val_count  = '0;
                     end else begin
                        text_phase = TX_SKIP;
                     end
                  end else begin
                     if (key_pos >= KEY_LEN) begin
                        key_ok = 1'b0;
                     end else if (TITLE_KEY[8*(10-int'(key_pos)) +: 8] != b) begin
                        key_ok = 1'b0;
                     end
                     if (key_pos < KEYPOS_TOP) key_pos = key_pos + 1'b1;
                  end
               end
               TX_VALUE: begin
                  if (b == CHAR_NUL) begin
                     commit_title();
                     text_phase = TX_END;
                  end else if (b == CHAR_SEMI) begin
                     commit_title();
                     restart_text();
                  end else if (b == CHAR_EQUALS) begin
                     commit_title();
                     text_phase = TX_SKIP;
                  end else begin
                     if (val_count < TITLE_CAP) title_mem[int'(wb)*TITLE_CAP + int'(val_count)] = b;
                     if (val_count == '0) val_first = b;
                     val_last = b;
                     if (val_count < COUNT_TOP) val_count = val_count + 1'b1;
                  end
               end
               TX_SKIP: begin
                  if (b == CHAR_NUL) begin
                     text_phase = TX_END;
                  end else if (b == CHAR_SEMI) begin
                     restart_text();
                  end
               end
               default: begin
               end
            endcase
            if (meta_left != '0) meta_left = meta_left - 1'b1;
            if (meta_left == '0) begin
               if (text_phase == TX_VALUE) commit_title();
               bank      = ~bank;
               shown_len = work_len;
               shown_off = work_off;
               r.done    = 1'b1;
               restart_text();
               restart_audio();
            end
         end else begin
            r.cls = CLS_AUDIO;
            frame_phase = PH_AUDIO;
            if (audio_left == '0) audio_left = interval_reg;
            audio_left = audio_left - 1'b1;
            if (audio_left == '0) frame_phase = PH_LEN;
         end
      end else if (kind == KIND_RESTART) begin
         restart_audio();
         restart_text();
         work_len  = '0;
         work_off  = 1'b0;
         shown_len = '0;
         shown_off = 1'b0;
         cut_bits  = '0;
      end
      if (idx < shown_len) r.ch = title_mem[int'(bank)*TITLE_CAP + int'(shown_off) + int'(idx)];
      r.len = shown_len;
      r.cut = cut_bits[bank];
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want_v);
      if (error_count < 40) begin
         $display("mismatch on %s: got %0d, expected %0d (response %0d)",
                  field, got, want_v, responses_seen);
      end
      error_count++;
   endtask

   // ---------------------------------------------------------------- drivers

   function automatic logic [7:0] pick_index();
      if (shown_len != '0 && $urandom_range(99) < 60) begin
         return 8'($urandom_range(int'(shown_len) - 1));
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(255, 1));
      while (c == CHAR_SEMI || c == CHAR_EQUALS || c == CHAR_QUOTE) begin
         c = 8'($urandom_range(255, 1));
      end
      return c;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] idx);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.stream_byte <= b;
      req_if.title_index <= idx;
      do @(posedge clock); while (!req_if.ready);
      byte_reports.push_back(classify_and_parse(kind, b, idx));
      if (kind != KIND_SPARE) items_sent++;
   endtask

   // lets every pending transaction come back before the block is touched again
   task automatic settle();
      req_if.valid <= 1'b0;
      while (byte_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_interval(input logic [23:0] v);
      logic [CSR_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= INTERVAL_ADDR;
      pwdata  <= {8'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      interval_reg = v;
      // back-to-back read of the same register
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[23:0] !== v) flag_mismatch("data_interval readback", readback[23:0], v);
   endtask

   task automatic push_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) meta_text.push_back(s[i]);
   endtask

   task automatic push_value(input bit quoted, input int n);
      if (quoted) meta_text.push_back(CHAR_QUOTE);
      repeat (n) meta_text.push_back(text_char());
      if (quoted) meta_text.push_back(CHAR_QUOTE);
   endtask

   // random metadata text: titles, other keys, broken keys, stray separators
   task automatic build_meta();
      int parts;
      int p;
      meta_text.delete();
      parts = $urandom_range(3, 1);
      for (p = 0; p < parts; p++) begin
         if (p > 0) meta_text.push_back(CHAR_SEMI);
         case ($urandom_range(10))
            0, 1, 2: begin
               push_str("StreamTitle=");
               push_value(1'($urandom_range(1)), $urandom_range(24));
            end
            3: push_str("StreamTitle=''");
            4: begin
               push_str("StreamTitle='");
               push_value(1'b0, $urandom_range(5));
            end
            5: begin
               push_str("StreamUrl=");
               push_value(1'b1, $urandom_range(12));
            end
            6: begin
               case ($urandom_range(5))
                  0: push_str("StreamTitl");
                  1: push_str("StreamTitleX");
                  2: push_str("streamTitle");
                  3: push_str("XStreamTitle");
                  4: push_str("StreamTitlf");
                  default: push_str("StreamTitleStreamTitle");
               endcase
               meta_text.push_back(CHAR_EQUALS);
               push_value(1'($urandom_range(1)), $urandom_range(8));
            end
            7: push_str("StreamTitle");
            8: push_str("StreamTitle='a=b'");
            default: repeat ($urandom_range(20, 1)) meta_text.push_back(8'($urandom_range(255, 1)));
         endcase
      end
      if ($urandom_range(99) < 50) meta_text.push_back(CHAR_SEMI);
      if ($urandom_range(99) < 70) meta_text.push_back(CHAR_NUL);
   endtask

   // audio run, length byte and metadata block; forced_len < 0 draws a random frame
   task automatic send_frame(input int forced_len);
      int         len_byte;
      int         need;
      int         span;
      int         cut_at;
      int         i;
      int         j;
      bit         pad_zero;
      logic [7:0] b;
      cut_at   = -1;
      pad_zero = 1'($urandom_range(1));
      if (forced_len >= 0) begin
         len_byte = forced_len;
      end else begin
         if ($urandom_range(99) < 4) begin
            // noise, then back in step
            repeat ($urandom_range(12, 1)) send_item(KIND_BYTE, 8'($urandom), pick_index());
            send_item(KIND_RESTART, 8'($urandom), pick_index());
            return;
         end
         build_meta();
         need = (meta_text.size() + 15) / 16;
         len_byte = need + $urandom_range(1);
         j = $urandom_range(99);
         if (j < 8) len_byte = $urandom_range(need > 1 ? need : 1, 1);
         else if (j < 12) len_byte = 0;
         if (len_byte > 255) len_byte = 255;
      end
      span = int'(interval_reg) + 1 + 16 * len_byte;
      if (forced_len < 0 && $urandom_range(99) < 8) cut_at = $urandom_range(span - 1);
      for (i = 0; i < span; i++) begin
         if (i == cut_at) begin
            send_item(KIND_RESTART, 8'($urandom), pick_index());
            return;
         end
         if ($urandom_range(99) < 6) send_item(KIND_READ, 8'($urandom), pick_index());
         if ($urandom_range(99) < 1) send_item(KIND_SPARE, 8'($urandom), 8'($urandom));
         if (i < int'(interval_reg)) begin
            b = 8'($urandom);
         end else if (i == int'(interval_reg)) begin
            b = 8'(len_byte);
         end else begin
            j = i - int'(interval_reg) - 1;
            if (j < meta_text.size()) b = meta_text[j];
            else b = pad_zero ? CHAR_NUL : 8'($urandom);
         end
         send_item(KIND_BYTE, b, pick_index());
      end
   endtask

   task automatic read_probes();
      send_item(KIND_READ, 8'($urandom), 8'd0);
      send_item(KIND_READ, 8'($urandom), 8'd254);
      send_item(KIND_READ, 8'($urandom), 8'd255);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_framing();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      send_item(KIND_BYTE, 8'h00, 8'h00);
      send_item(KIND_BYTE, 8'hff, 8'hff);
      settle();
      write_interval(24'd1);
      send_item(KIND_RESTART, 8'h00, 8'h00);
      send_frame(0);
      meta_text.delete();
      push_str("StreamTitle='Q'");
      meta_text.push_back(CHAR_NUL);
      send_frame(1);
      send_item(KIND_READ, 8'h00, 8'd0);
      send_item(KIND_READ, 8'hff, 8'd255);
      send_item(KIND_SPARE, 8'h5a, 8'h00);
      settle();
   endtask

   task automatic test_interval_extremes();
      write_interval(24'hffffff);
      send_item(KIND_RESTART, 8'h00, 8'h00);
      repeat (4) send_item(KIND_BYTE, 8'($urandom), pick_index());
      settle();
      // pass-through, then a restart leaves an empty audio count behind
      write_interval(24'd0);
      repeat (2) send_item(KIND_BYTE, 8'($urandom), pick_index());
      send_item(KIND_RESTART, 8'h00, 8'h00);
      settle();
      write_interval(24'd2);
      repeat (3) send_frame(-1);
      settle();
   endtask

   task automatic test_long_titles();
      write_interval(24'd1);
      send_item(KIND_RESTART, 8'h00, 8'h00);
      // quoted and far too long
      meta_text.delete();
      push_str("StreamTitle='");
      push_value(1'b0, 300);
      push_str("';");
      meta_text.push_back(CHAR_NUL);
      send_frame(20);
      read_probes();
      // unquoted value cut off by the block end
      meta_text.delete();
      push_str("StreamTitle=");
      push_value(1'b0, 260);
      send_frame(17);
      read_probes();
      // quoted value that just fits
      meta_text.delete();
      push_str("StreamTitle=");
      push_value(1'b1, 255);
      meta_text.push_back(CHAR_NUL);
      send_frame(17);
      read_probes();
      settle();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      write_interval(24'd3);
      send_item(KIND_RESTART, 8'h00, 8'h00);
      hold_left = 300;
      repeat (4) send_frame(-1);
      settle();
   endtask

   task automatic test_random_frames(input int send_pct, input int sink_pct, input int budget);
      int round;
      int stop;
      send_idle_pct  = send_pct;
      sink_stall_pct = sink_pct;
      for (round = 0; round < 2; round++) begin
         settle();
         write_interval(round == 0 ? 24'($urandom_range(4, 1)) : 24'($urandom_range(12, 1)));
         send_item(KIND_RESTART, 8'($urandom), pick_index());
         stop = items_sent + budget / 2;
         while (items_sent < stop) send_frame(-1);
      end
      settle();
   endtask

   // ---------------------------------------------------------------- sink side

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      byte_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (byte_reports.size() == 0) begin
            flag_mismatch("transaction with nothing pending", 1, 0);
         end else begin
            want = byte_reports.pop_front();
            if (rsp_if.byte_class !== want.cls)
               flag_mismatch("byte_class", rsp_if.byte_class, want.cls);
            if (rsp_if.byte_out !== want.data)
               flag_mismatch("byte_out", rsp_if.byte_out, want.data);
            if (rsp_if.block_done !== want.done)
               flag_mismatch("block_done", rsp_if.block_done, want.done);
            if (rsp_if.title_char !== want.ch)
               flag_mismatch("title_char", rsp_if.title_char, want.ch);
            if (rsp_if.title_length !== want.len)
               flag_mismatch("title_length", rsp_if.title_length, want.len);
            if (rsp_if.title_truncated !== want.cut)
               flag_mismatch("title_truncated", rsp_if.title_truncated, want.cut);
         end
         responses_seen++;
      end
   end

   // no transaction in either direction for too long means a hang
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_icy_metadata_stream_demux_top failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.kind        = KIND_BYTE;
      req_if.stream_byte = '0;
      req_if.title_index = '0;
      rsp_if.ready       = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      error_count        = 0;
      responses_seen     = 0;
      items_sent         = 0;
      quiet_cycles       = 0;
      send_idle_pct      = 0;
      sink_stall_pct     = 0;
      hold_left          = 0;
      interval_reg       = '0;
      restart_audio();
      restart_text();
      bank      = 1'b0;
      work_len  = '0;
      work_off  = 1'b0;
      shown_len = '0;
      shown_off = 1'b0;
      cut_bits  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_framing();
      test_interval_extremes();
      test_long_titles();
      test_backpressure();
      test_random_frames(0, 0, 100);
      test_random_frames(86, 0, 100);
      test_random_frames(0, 86, 100);
      test_random_frames(30, 30, 100);

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_icy_metadata_stream_demux_top passed");
      end else begin
         $display("tb_icy_metadata_stream_demux_top failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/icy_pkg.sv
rtl/icy_req_if.sv
rtl/icy_rsp_if.sv
rtl/icy_metadata_stream_demux_top.sv
tb/tb_icy_metadata_stream_demux_top.sv
